/* design/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg: shared types, codes and decode functions
// Character codes, operator table, character classes, emit selects and the
// command/status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package itp_pkg;

   // Default operator stack depth
   localparam int STACK_DEPTH = 16;

   // ASCII characters of interest
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // Stack symbol codes
   localparam logic [2:0] SYM_MINUS  = 3'd0;
   localparam logic [2:0] SYM_PLUS   = 3'd1;
   localparam logic [2:0] SYM_SLASH  = 3'd2;
   localparam logic [2:0] SYM_STAR   = 3'd3;
   localparam logic [2:0] SYM_CARET  = 3'd4;
   localparam logic [2:0] SYM_TILDE  = 3'd5;
   localparam logic [2:0] SYM_LPAREN = 3'd6;
   localparam logic [2:0] SYM_NONE   = 3'd7;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNMATCHED = 2'd2;

   // Character classes
   localparam logic [2:0] CLS_OTHER  = 3'd0;
   localparam logic [2:0] CLS_ALNUM  = 3'd1;
   localparam logic [2:0] CLS_SPACE  = 3'd2;
   localparam logic [2:0] CLS_LPAREN = 3'd3;
   localparam logic [2:0] CLS_RPAREN = 3'd4;
   localparam logic [2:0] CLS_OPER   = 3'd5;

   // Emit selects
   localparam logic [1:0] EMIT_SPACE = 2'd0;
   localparam logic [1:0] EMIT_CHAR  = 2'd1;
   localparam logic [1:0] EMIT_TOP   = 2'd2;
   localparam logic [1:0] EMIT_ZERO  = 2'd3;

   typedef struct packed {
      logic       load;          // latch the accepted beat
      logic       finish;        // release the held beat as the last one
      logic       emit;          // produce one result beat
      logic [1:0] emit_sel;
      logic [1:0] emit_status;
      logic       set_inside;
      logic       clr_inside;
      logic       push_lparen;
      logic       push_op;
      logic       pop;
      logic       clear_expr;
   } cmd_type;

   typedef struct packed {
      logic [2:0] cls;
      logic       end_flag;
      logic       need_space;
      logic       empty;
      logic       full;
      logic       top_ge;
      logic       top_is_lparen;
      logic       lparen_present;
      logic       slot_free;
   } status_type;

   // Map an operator character to its symbol code
   function automatic logic [2:0] op_code(input logic [7:0] c);
      logic [2:0] code;
      unique case (c)
         CH_MINUS: code = SYM_MINUS;
         CH_PLUS:  code = SYM_PLUS;
         CH_SLASH: code = SYM_SLASH;
         CH_STAR:  code = SYM_STAR;
         CH_CARET: code = SYM_CARET;
         CH_TILDE: code = SYM_TILDE;
         default:  code = SYM_NONE;
      endcase
      return code;
   endfunction

   // Map a symbol code back to its character
   function automatic logic [7:0] sym_char(input logic [2:0] code);
      logic [7:0] c;
      unique case (code)
         SYM_PLUS:   c = CH_PLUS;
         SYM_SLASH:  c = CH_SLASH;
         SYM_STAR:   c = CH_STAR;
         SYM_CARET:  c = CH_CARET;
         SYM_TILDE:  c = CH_TILDE;
         SYM_LPAREN: c = CH_LPAREN;
         default:    c = CH_MINUS;
      endcase
      return c;
   endfunction

   // Precedence; '(' is lowest so it stops operator pops
   function automatic logic [1:0] prec(input logic [2:0] code);
      logic [1:0] p;
      unique case (code)
         SYM_SLASH, SYM_STAR:  p = 2'd2;
         SYM_CARET, SYM_TILDE: p = 2'd3;
         SYM_LPAREN:           p = 2'd0;
         default:              p = 2'd1;
      endcase
      return p;
   endfunction

   // Sort a character into its class
   function automatic logic [2:0] classify(input logic [7:0] c);
      logic [2:0] cls;
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A)) begin
         cls = CLS_ALNUM;
      end else if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
         cls = CLS_SPACE;
      end else if (c == CH_LPAREN) begin
         cls = CLS_LPAREN;
      end else if (c == CH_RPAREN) begin
         cls = CLS_RPAREN;
      end else if (op_code(c) != SYM_NONE) begin
         cls = CLS_OPER;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

endpackage

/* design/itp_ctrl.sv */
// ----------------------------------------------------------------------------
// itp_ctrl: converter sequencer
// Walks each accepted character through operand copy, operator pops, pushes,
// parenthesis matching and the end-of-expression flush, one beat per cycle while a slot is free.
// ----------------------------------------------------------------------------
module itp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  itp_pkg::status_type st,
   output itp_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_CHAR  = 3'd2;
   localparam logic [2:0] S_POPOP = 3'd3;
   localparam logic [2:0] S_POPCH = 3'd4;
   localparam logic [2:0] S_POPRP = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;

   localparam logic [1:0] RET_OP    = 2'd0;
   localparam logic [1:0] RET_RP    = 2'd1;
   localparam logic [1:0] RET_FLUSH = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] ret_ff, ret_in;
   logic [2:0] done_state;

   // Decide commands and next state
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      ret_in     = ret_ff;
      req_ready  = 1'b0;
      done_state = st.end_flag ? S_FLUSH : S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.finish = 1'b1;
            req_ready  = st.slot_free;
            if (req_valid && st.slot_free) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (st.cls)
               itp_pkg::CLS_ALNUM: begin
                  if (st.slot_free) begin
                     cmd.emit = 1'b1;
                     if (st.need_space) begin
                        cmd.emit_sel = itp_pkg::EMIT_SPACE;
                        state_in     = S_CHAR;
                     end else begin
                        cmd.emit_sel   = itp_pkg::EMIT_CHAR;
                        cmd.set_inside = 1'b1;
                        state_in       = done_state;
                     end
                  end
               end
               itp_pkg::CLS_LPAREN: begin
                  cmd.clr_inside = 1'b1;
                  if (st.full) begin
                     if (st.slot_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_sel    = itp_pkg::EMIT_ZERO;
                        cmd.emit_status = itp_pkg::ST_OVERFLOW;
                        state_in        = done_state;
                     end
                  end else begin
                     cmd.push_lparen = 1'b1;
                     state_in        = done_state;
                  end
               end
               itp_pkg::CLS_OPER: begin
                  cmd.clr_inside = 1'b1;
                  state_in       = S_POPOP;
               end
               itp_pkg::CLS_RPAREN: begin
                  cmd.clr_inside = 1'b1;
                  if (st.lparen_present) begin
                     state_in = S_POPRP;
                  end else if (st.slot_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_sel    = itp_pkg::EMIT_ZERO;
                     cmd.emit_status = itp_pkg::ST_UNMATCHED;
                     state_in        = done_state;
                  end
               end
               default: begin
                  cmd.clr_inside = 1'b1;
                  state_in       = done_state;
               end
            endcase
         end
         S_CHAR: begin
            if (st.slot_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_sel   = itp_pkg::EMIT_CHAR;
               cmd.set_inside = 1'b1;
               state_in       = done_state;
            end
         end
         S_POPOP: begin
            // pop while top binds at least as tightly, then push
            if (!st.empty && st.top_ge) begin
               if (st.slot_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = itp_pkg::EMIT_SPACE;
                  ret_in       = RET_OP;
                  state_in     = S_POPCH;
               end
            end else if (st.full) begin
               if (st.slot_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_sel    = itp_pkg::EMIT_ZERO;
                  cmd.emit_status = itp_pkg::ST_OVERFLOW;
                  state_in        = done_state;
               end
            end else begin
               cmd.push_op = 1'b1;
               state_in    = done_state;
            end
         end
         S_POPCH: begin
            if (st.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = itp_pkg::EMIT_TOP;
               cmd.pop      = 1'b1;
               unique case (ret_ff)
                  RET_OP:  state_in = S_POPOP;
                  RET_RP:  state_in = S_POPRP;
                  default: state_in = S_FLUSH;
               endcase
            end
         end
         S_POPRP: begin
            // pop down to the matching '(' and drop it
            if (st.top_is_lparen) begin
               cmd.pop  = 1'b1;
               state_in = done_state;
            end else if (st.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = itp_pkg::EMIT_SPACE;
               ret_in       = RET_RP;
               state_in     = S_POPCH;
            end
         end
         S_FLUSH: begin
            if (!st.empty) begin
               if (st.slot_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = itp_pkg::EMIT_SPACE;
                  ret_in       = RET_FLUSH;
                  state_in     = S_POPCH;
               end
            end else begin
               cmd.clear_expr = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_OP;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // Check sequencing rules
   a_emit_has_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.slot_free)
      else $error("beat produced without a free slot");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !st.empty)
      else $error("pop from an empty stack");

   a_load_from_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_EXEC)
      else $error("accepted beat not dispatched");

endmodule

/* design/itp_datapath.sv */
// ----------------------------------------------------------------------------
// itp_datapath: operator stack, expression flags and result beat path
// Holds the current character, the operator stack with its counts, one held
// result beat and the output register.
// ----------------------------------------------------------------------------
module itp_datapath #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  itp_pkg::cmd_type    cmd,
   output itp_pkg::status_type st,
   input  logic [7:0]          req_in_char,
   input  logic                req_end_of_expr,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_last_out,
   output logic [1:0]          rsp_status
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   logic [2:0]       stack_ff [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lparen_ff, lparen_in;
   logic             started_ff, started_in;
   logic             inside_ff, inside_in;
   logic [7:0]       char_ff;
   logic             end_ff;
   logic             pend_v_ff;
   logic [7:0]       pend_char_ff;
   logic [1:0]       pend_status_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_last_ff;
   logic [1:0]       rsp_status_ff;

   logic [CNT_W-1:0] top_pos;
   logic [IDX_W-1:0] top_idx;
   logic [IDX_W-1:0] push_idx;
   logic [2:0]       top_code;
   logic [2:0]       cur_op;
   logic             out_free;
   logic             release_last;
   logic [7:0]       emit_char;

   // Decode stack top and current character
   always_comb begin
      top_pos      = count_ff - CNT_W'(1);
      top_idx      = top_pos[IDX_W-1:0];
      push_idx     = count_ff[IDX_W-1:0];
      top_code     = stack_ff[top_idx];
      cur_op       = itp_pkg::op_code(char_ff);
      out_free     = !rsp_valid_ff || rsp_ready;
      release_last = cmd.finish && pend_v_ff && out_free;

      st.cls            = itp_pkg::classify(char_ff);
      st.end_flag       = end_ff;
      st.need_space     = !inside_ff && started_ff;
      st.empty          = (count_ff == '0);
      st.full           = (count_ff >= CNT_W'(STACK_DEPTH));
      st.top_ge         = itp_pkg::prec(top_code) >= itp_pkg::prec(cur_op);
      st.top_is_lparen  = (top_code == itp_pkg::SYM_LPAREN);
      st.lparen_present = (lparen_ff != '0);
      st.slot_free      = !pend_v_ff || out_free;
   end

   // Select the character of a new beat
   always_comb begin
      case (cmd.emit_sel)
         itp_pkg::EMIT_SPACE: emit_char = itp_pkg::CH_SPACE;
         itp_pkg::EMIT_CHAR:  emit_char = char_ff;
         itp_pkg::EMIT_TOP:   emit_char = itp_pkg::sym_char(top_code);
         default:             emit_char = itp_pkg::CH_NUL;
      endcase
   end

   // Update counts and expression flags
   always_comb begin
      count_in   = count_ff;
      lparen_in  = lparen_ff;
      started_in = started_ff;
      inside_in  = inside_ff;
      if (cmd.push_lparen) begin
         count_in  = count_ff + CNT_W'(1);
         lparen_in = lparen_ff + CNT_W'(1);
      end else if (cmd.push_op) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = top_pos;
         if (top_code == itp_pkg::SYM_LPAREN) begin
            lparen_in = lparen_ff - CNT_W'(1);
         end
      end
      if (cmd.emit) begin
         started_in = 1'b1;
      end
      if (cmd.set_inside) begin
         inside_in = 1'b1;
      end else if (cmd.clr_inside) begin
         inside_in = 1'b0;
      end
      if (cmd.clear_expr) begin
         count_in   = '0;
         lparen_in  = '0;
         started_in = 1'b0;
         inside_in  = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         lparen_ff  <= '0;
         started_ff <= 1'b0;
         inside_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         lparen_ff  <= lparen_in;
         started_ff <= started_in;
         inside_ff  <= inside_in;
      end
   end

   // Latch the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= req_in_char;
         end_ff  <= req_end_of_expr;
      end
   end

   // Push onto the operator stack
   always_ff @(posedge clock) begin
      if (cmd.push_lparen) begin
         stack_ff[push_idx] <= itp_pkg::SYM_LPAREN;
      end else if (cmd.push_op) begin
         stack_ff[push_idx] <= cur_op;
      end
   end

   // Hold one beat back so the last one of an item can be marked
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
      end else if (cmd.emit) begin
         pend_v_ff <= 1'b1;
      end else if (release_last) begin
         pend_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pend_char_ff   <= emit_char;
         pend_status_ff <= cmd.emit_status;
      end
   end

   // Drive the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.emit && pend_v_ff) || release_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.emit && pend_v_ff) || release_last) begin
         rsp_char_ff   <= pend_char_ff;
         rsp_status_ff <= pend_status_ff;
         rsp_last_ff   <= release_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last_out = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;

   // Check stack bookkeeping
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_op || cmd.push_lparen) |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("push did not advance the stack count");

   a_lparen_bound: assert property (@(posedge clock) disable iff (reset)
      lparen_ff <= count_ff)
      else $error("more '(' counted than stacked");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !((cmd.emit && pend_v_ff) || release_last))
      else $error("output register overwritten while stalled");

endmodule

/* design/infix_to_postfix_converter_core.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core: shunting-yard infix to postfix converter
// A result beat passes through the held-beat register and then the output
// register; the held beat is released as the last one once back in idle.
// A new character is taken only in idle, after the last one is done. A character
// gives one result or none, a leading space and the operand, or for each stack
// pop a space and the operator, one beat per cycle while a slot is free.
// An end-marked character then flushes every stacked entry the same way.
// Reset clears the stack count, expression flags and all valid state at once.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_out,
   output logic [1:0] rsp_status
);

   itp_pkg::cmd_type    cmd;
   itp_pkg::status_type st;

   // Sequence each character
   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Stack, flags and result path
   itp_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_in_char     (req_in_char),
      .req_end_of_expr (req_end_of_expr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_out    (rsp_last_out),
      .rsp_status      (rsp_status)
   );

endmodule
